FILE: rtl/core/wave_chunk_stream_parser_defines.svh
// Assertion macros used by the wave chunk stream parser checker.
`ifndef WAVE_CHUNK_STREAM_PARSER_DEFINES_SVH
`define WAVE_CHUNK_STREAM_PARSER_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off while in reset.
`define WCSP_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off while in reset.
`define WCSP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/core/wcsp_pkg.sv
// Shared types and constants of the wave chunk stream parser.
package wcsp_pkg;

	// Chunk ids and the RIFF form type, little-endian as assembled
	localparam logic [31:0] TAG_WAVE = 32'h45564157;
	localparam logic [31:0] TAG_RIFF = 32'h46464952;
	localparam logic [31:0] TAG_FMT  = 32'h20746d66;
	localparam logic [31:0] TAG_DATA = 32'h61746164;

	// Result kinds
	localparam logic [1:0] KIND_AUDIO  = 2'd0;
	localparam logic [1:0] KIND_FORMAT = 2'd1;
	localparam logic [1:0] KIND_DATA   = 2'd2;
	localparam logic [1:0] KIND_ERROR  = 2'd3;

	// Error codes
	localparam logic [1:0] ERR_NONE     = 2'd0;
	localparam logic [1:0] ERR_BAD_WAVE = 2'd1;
	localparam logic [1:0] ERR_ZERO_DIV = 2'd2;

	// Sample format codes
	localparam logic [2:0] FMT_UNKNOWN = 3'd0;
	localparam logic [2:0] FMT_S8      = 3'd1;
	localparam logic [2:0] FMT_S16     = 3'd2;
	localparam logic [2:0] FMT_S24     = 3'd3;
	localparam logic [2:0] FMT_S32     = 3'd4;
	localparam logic [2:0] FMT_FLOAT32 = 3'd5;

	// Format tags in the fmt chunk
	localparam logic [15:0] WAVE_FMT_PCM   = 16'd1;
	localparam logic [15:0] WAVE_FMT_FLOAT = 16'd3;

	// Byte positions within each parse phase
	localparam logic [4:0] TAG_BYTES = 5'd4;
	localparam logic [4:0] HDR_LAST  = 5'd7;
	localparam logic [4:0] WAVE_LAST = 5'd3;
	localparam logic [4:0] FMT_LAST  = 5'd15;
	localparam logic [31:0] FMT_BYTES = 32'd16;

	// Divider geometry: 32-bit size over a 13-bit bytes-per-sample
	localparam int DIVIDEND_W = 32;
	localparam int DIVISOR_W  = 13;
	localparam logic [4:0] DIV_LAST = 5'd31;

	typedef enum logic [2:0] {
		PH_HEADER,
		PH_WAVE,
		PH_FMT,
		PH_SKIP,
		PH_AUDIO,
		PH_HALT,
		PH_DIVIDE
	} phase_t;

	// Datapath to controller
	typedef struct packed {
		logic [4:0] count;
		logic       tag_riff;
		logic       tag_fmt;
		logic       tag_data;
		logic       wave_ok;
		logic       len_zero;
		logic       len_gt16;
		logic       skip_last;
		logic       div_zero;
		logic       div_done;
		logic       out_free;
	} dp_status_t;

	// Controller to datapath
	typedef struct packed {
		logic       cnt_inc;
		logic       cnt_clr;
		logic       tag_shift;
		logic       len_shift;
		logic       fmt_shift;
		logic       fmt_commit;
		logic       skip_from_len;
		logic       skip_from_fmt;
		logic       skip_dec;
		logic       div_start;
		logic       out_load;
		logic [1:0] out_kind;
		logic [1:0] out_err;
	} dp_cmd_t;

endpackage

FILE: rtl/core/wcsp_div.sv
// Restoring divider, one quotient bit per cycle, for the sample count.
module wcsp_div (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [wcsp_pkg::DIVIDEND_W-1:0] dividend,
	input  logic [wcsp_pkg::DIVISOR_W-1:0]  divisor,
	output logic                            done,
	output logic [wcsp_pkg::DIVIDEND_W-1:0] quotient
);
	import wcsp_pkg::*;

	logic                  busy_q;
	logic                  done_q;
	logic [4:0]            step_q;
	logic [DIVISOR_W-1:0]  rem_q;
	logic [DIVISOR_W-1:0]  dvs_q;
	logic [DIVIDEND_W-1:0] quo_q;
	logic [DIVISOR_W:0]    rem_sh;
	logic [DIVISOR_W:0]    rem_diff;
	logic                  q_bit;
	logic [DIVISOR_W-1:0]  rem_next;

	// One trial subtraction per step
	always_comb begin
		rem_sh   = {rem_q, quo_q[DIVIDEND_W-1]};
		rem_diff = rem_sh - {1'b0, dvs_q};
		q_bit    = (rem_sh >= {1'b0, dvs_q});
		rem_next = q_bit ? rem_diff[DIVISOR_W-1:0] : rem_sh[DIVISOR_W-1:0];
	end

	// Step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= busy_q && (step_q == DIV_LAST);
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 5'd1;
				if (step_q == DIV_LAST) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// Remainder and dividend/quotient shift register
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvs_q <= divisor;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= rem_next;
			quo_q <= {quo_q[DIVIDEND_W-2:0], q_bit};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

FILE: rtl/core/wcsp_dp.sv
// Datapath: byte counter, chunk registers, format store, divider and result register.
module wcsp_dp (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [7:0]           stream_byte,
	input  logic                 out_ready,
	input  wcsp_pkg::dp_cmd_t    cmd,
	output wcsp_pkg::dp_status_t status,
	output logic                 out_valid,
	output logic [1:0]           result_kind,
	output logic [7:0]           audio_byte,
	output logic [2:0]           sample_format,
	output logic [15:0]          channel_count,
	output logic [31:0]          sample_rate,
	output logic [15:0]          sample_bits,
	output logic [31:0]          total_samples,
	output logic [1:0]           error_code
);
	import wcsp_pkg::*;

	logic [4:0]   count_q;
	logic [31:0]  tag_q;
	logic [31:0]  len_q;
	logic [31:0]  skip_q;
	logic [127:0] fmt_q;
	logic [2:0]   format_q;
	logic [15:0]  chan_q;
	logic [31:0]  rate_q;
	logic [15:0]  bits_q;
	logic         out_valid_q;
	logic [1:0]   kind_q;
	logic [7:0]   audio_q;
	logic [31:0]  total_q;
	logic [1:0]   err_q;

	logic [31:0]  next_tag;
	logic [31:0]  next_len;
	logic [127:0] next_fmt;
	logic [15:0]  new_bits;
	logic [2:0]   code_d;
	logic         div_done;
	logic [31:0]  quotient;

	// Little-endian assembly: the new byte enters at the top
	assign next_tag = {stream_byte, tag_q[31:8]};
	assign next_len = {stream_byte, len_q[31:8]};
	assign next_fmt = {stream_byte, fmt_q[127:8]};
	assign new_bits = next_fmt[127:112];

	// Format code decode; unknown combinations keep the previous code
	always_comb begin
		code_d = format_q;
		if (next_fmt[15:0] == WAVE_FMT_PCM) begin
			unique case (new_bits)
				16'd8:   code_d = FMT_S8;
				16'd16:  code_d = FMT_S16;
				16'd24:  code_d = FMT_S24;
				16'd32:  code_d = FMT_S32;
				default: code_d = format_q;
			endcase
		end else if (next_fmt[15:0] == WAVE_FMT_FLOAT) begin
			code_d = FMT_FLOAT32;
		end
	end

	// Parser control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			tag_q    <= '0;
			len_q    <= '0;
			skip_q   <= '0;
			format_q <= FMT_UNKNOWN;
			chan_q   <= '0;
			rate_q   <= '0;
			bits_q   <= '0;
		end else begin
			if (cmd.cnt_clr) begin
				count_q <= '0;
			end else if (cmd.cnt_inc) begin
				count_q <= count_q + 5'd1;
			end
			if (cmd.tag_shift) begin
				tag_q <= next_tag;
			end
			if (cmd.len_shift) begin
				len_q <= next_len;
			end
			if (cmd.skip_from_len) begin
				skip_q <= next_len;
			end else if (cmd.skip_from_fmt) begin
				skip_q <= len_q - FMT_BYTES;
			end else if (cmd.skip_dec && (skip_q != '0)) begin
				skip_q <= skip_q - 32'd1;
			end
			if (cmd.fmt_commit) begin
				format_q <= code_d;
				chan_q   <= next_fmt[31:16];
				rate_q   <= next_fmt[63:32];
				bits_q   <= new_bits;
			end
		end
	end

	// Format byte store, decoded only once all 16 bytes are in
	always_ff @(posedge clk) begin
		if (cmd.fmt_shift) begin
			fmt_q <= next_fmt;
		end
	end

	// Bytes per sample is bits / 8
	wcsp_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (next_len),
		.divisor  (bits_q[15:3]),
		.done     (div_done),
		.quotient (quotient)
	);

	// Result register: holds a beat until the receiver takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			kind_q  <= cmd.out_kind;
			err_q   <= cmd.out_err;
			audio_q <= (cmd.out_kind == KIND_AUDIO) ? stream_byte : 8'd0;
			total_q <= (cmd.out_kind == KIND_DATA) ? quotient : 32'd0;
		end
	end

	// Status toward the controller
	always_comb begin
		status.count     = count_q;
		status.tag_riff  = (tag_q == TAG_RIFF);
		status.tag_fmt   = (tag_q == TAG_FMT);
		status.tag_data  = (tag_q == TAG_DATA);
		status.wave_ok   = (next_tag == TAG_WAVE);
		status.len_zero  = (next_len == '0);
		status.len_gt16  = (len_q > FMT_BYTES);
		status.skip_last = (skip_q <= 32'd1);
		status.div_zero  = (bits_q[15:3] == '0);
		status.div_done  = div_done;
		status.out_free  = !out_valid_q || out_ready;
	end

	assign out_valid     = out_valid_q;
	assign result_kind   = kind_q;
	assign audio_byte    = audio_q;
	assign total_samples = total_q;
	assign error_code    = err_q;
	assign sample_format = format_q;
	assign channel_count = chan_q;
	assign sample_rate   = rate_q;
	assign sample_bits   = bits_q;

endmodule

FILE: rtl/core/wcsp_ctrl.sv
// Controller: parse phase state machine that steers the datapath.
module wcsp_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  wcsp_pkg::dp_status_t status,
	output wcsp_pkg::dp_cmd_t    cmd
);
	import wcsp_pkg::*;

	phase_t state_q;
	phase_t state_d;
	logic   accept;

	// Input stalls during the divide and while a result beat waits
	assign in_ready = (state_q != PH_DIVIDE) && status.out_free;
	assign accept   = in_valid && in_ready;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= PH_HEADER;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			PH_HEADER: begin
				if (accept && (status.count == HDR_LAST)) begin
					priority if (status.tag_riff) begin
						state_d = PH_WAVE;
					end else if (status.tag_fmt) begin
						state_d = PH_FMT;
					end else if (status.tag_data) begin
						state_d = status.div_zero ? PH_HALT : PH_DIVIDE;
					end else begin
						state_d = status.len_zero ? PH_HEADER : PH_SKIP;
					end
				end
			end
			PH_WAVE: begin
				if (accept && (status.count == WAVE_LAST)) begin
					state_d = status.wave_ok ? PH_HEADER : PH_HALT;
				end
			end
			PH_FMT: begin
				if (accept && (status.count == FMT_LAST)) begin
					state_d = status.len_gt16 ? PH_SKIP : PH_HEADER;
				end
			end
			PH_SKIP: begin
				if (accept && status.skip_last) begin
					state_d = PH_HEADER;
				end
			end
			PH_DIVIDE: begin
				if (status.div_done) begin
					state_d = PH_AUDIO;
				end
			end
			PH_AUDIO: state_d = PH_AUDIO;
			PH_HALT:  state_d = PH_HALT;
			default:  state_d = PH_HEADER;
		endcase
	end

	// Datapath commands
	always_comb begin
		cmd = '0;
		unique case (state_q)
			PH_HEADER: begin
				if (accept) begin
					if (status.count < TAG_BYTES) begin
						cmd.tag_shift = 1'b1;
					end else begin
						cmd.len_shift = 1'b1;
					end
					if (status.count == HDR_LAST) begin
						cmd.cnt_clr = 1'b1;
						priority if (status.tag_riff || status.tag_fmt) begin
							cmd.cnt_clr = 1'b1;
						end else if (status.tag_data) begin
							if (status.div_zero) begin
								cmd.out_load = 1'b1;
								cmd.out_kind = KIND_ERROR;
								cmd.out_err  = ERR_ZERO_DIV;
							end else begin
								cmd.div_start = 1'b1;
							end
						end else begin
							cmd.skip_from_len = 1'b1;
						end
					end else begin
						cmd.cnt_inc = 1'b1;
					end
				end
			end
			PH_WAVE: begin
				if (accept) begin
					cmd.tag_shift = 1'b1;
					if (status.count == WAVE_LAST) begin
						cmd.cnt_clr = 1'b1;
						if (!status.wave_ok) begin
							cmd.out_load = 1'b1;
							cmd.out_kind = KIND_ERROR;
							cmd.out_err  = ERR_BAD_WAVE;
						end
					end else begin
						cmd.cnt_inc = 1'b1;
					end
				end
			end
			PH_FMT: begin
				if (accept) begin
					cmd.fmt_shift = 1'b1;
					if (status.count == FMT_LAST) begin
						cmd.cnt_clr       = 1'b1;
						cmd.fmt_commit    = 1'b1;
						cmd.skip_from_fmt = status.len_gt16;
						cmd.out_load      = 1'b1;
						cmd.out_kind      = KIND_FORMAT;
						cmd.out_err       = ERR_NONE;
					end else begin
						cmd.cnt_inc = 1'b1;
					end
				end
			end
			PH_SKIP: begin
				cmd.skip_dec = accept;
			end
			PH_DIVIDE: begin
				if (status.div_done) begin
					cmd.out_load = 1'b1;
					cmd.out_kind = KIND_DATA;
					cmd.out_err  = ERR_NONE;
				end
			end
			PH_AUDIO: begin
				if (accept) begin
					cmd.out_load = 1'b1;
					cmd.out_kind = KIND_AUDIO;
					cmd.out_err  = ERR_NONE;
				end
			end
			PH_HALT: cmd = '0;
			default: cmd = '0;
		endcase
	end

endmodule

FILE: rtl/core/wave_chunk_stream_parser.sv
// Top level of the wave chunk stream parser: controller plus datapath.
// Input channel: one file byte per beat on stream_byte (in_valid / in_ready).
// Output channel: one result beat (out_valid / out_ready) carrying result_kind,
// audio_byte, the held format fields, total_samples and error_code.
// A byte that yields a result shows it on the output register in the cycle
// after acceptance. Header, tag, format and skipped bytes mostly yield no beat.
// The data chunk header is the exception: its size goes through a restoring
// divider that retires one quotient bit a cycle, so in_ready stays low while
// it runs and the data beat appears when it is done.
// After the data header every byte returns as an audio beat, one per cycle unless stalled.
// A result beat waits in the output register while out_ready is low, and
// in_ready drops until it is taken, so nothing is lost or repeated.
// After an error beat the block keeps accepting bytes and drops them.
// Asynchronous reset (arst_n low) returns the parser to the chunk header phase
// with all held format values at zero and the output empty.
module wave_chunk_stream_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  stream_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  result_kind,
	output logic [7:0]  audio_byte,
	output logic [2:0]  sample_format,
	output logic [15:0] channel_count,
	output logic [31:0] sample_rate,
	output logic [15:0] sample_bits,
	output logic [31:0] total_samples,
	output logic [1:0]  error_code
);
	import wcsp_pkg::*;

	dp_status_t status;
	dp_cmd_t    cmd;

	wcsp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	wcsp_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.stream_byte   (stream_byte),
		.out_ready     (out_ready),
		.cmd           (cmd),
		.status        (status),
		.out_valid     (out_valid),
		.result_kind   (result_kind),
		.audio_byte    (audio_byte),
		.sample_format (sample_format),
		.channel_count (channel_count),
		.sample_rate   (sample_rate),
		.sample_bits   (sample_bits),
		.total_samples (total_samples),
		.error_code    (error_code)
	);

endmodule

FILE: rtl/core/wcsp_checker.sv
// Port-level checker for the wave chunk stream parser and its bind.
`include "wave_chunk_stream_parser_defines.svh"

module wcsp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [1:0]  result_kind,
	input logic [7:0]  audio_byte,
	input logic [31:0] total_samples,
	input logic [1:0]  error_code
);
	import wcsp_pkg::*;

	// A stalled result beat holds
	`WCSP_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(result_kind) && $stable(total_samples) && $stable(audio_byte), "stalled result beat changed")

	// Error code only on error beats
	`WCSP_ASSERT_SAME(a_err_only, clk, arst_n, out_valid && (result_kind != KIND_ERROR), error_code == ERR_NONE, "error code on a non-error beat")

	// Error beats carry a cause and no payload
	`WCSP_ASSERT_SAME(a_err_body, clk, arst_n, out_valid && (result_kind == KIND_ERROR), (error_code != ERR_NONE) && (total_samples == 32'd0) && (audio_byte == 8'd0), "malformed error beat")

	// Sample count only on data-start beats
	`WCSP_ASSERT_SAME(a_total_only, clk, arst_n, out_valid && (result_kind != KIND_DATA), total_samples == 32'd0, "sample count on a non-data beat")

	// Nothing follows an error
	`WCSP_ASSERT_NEXT(a_halt, clk, arst_n, out_valid && out_ready && (result_kind == KIND_ERROR), !out_valid, "result beat after an error")

endmodule

bind wave_chunk_stream_parser wcsp_checker u_wcsp_checker (.*);
